/* hdl/ffc_pkg.sv */
// ffc_pkg: shared types and constants of the frequency-of-frequency counter
// holds field widths, op and result codes, controller states and the
// command/status structs between ffc_ctrl and ffc_dp; depends on nothing
package ffc_pkg;

  // stream field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 10;
  localparam int unsigned THR_W    = 10;
  localparam int unsigned LIM_W    = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned RES_W    = 2;
  localparam int unsigned IN_TDW   = 24;
  localparam int unsigned OUT_TDW  = 16;

  localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd1023;

  // op codes
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // result status codes
  localparam logic [RES_W-1:0] RES_OK     = 2'd0;
  localparam logic [RES_W-1:0] RES_ABSENT = 2'd1;
  localparam logic [RES_W-1:0] RES_SAT    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_KCHK,
    S_LVL,
    S_LDIV,
    S_HRD,
    S_HWR,
    S_QDIVT,
    S_QDIVL,
    S_QHIST,
    S_QBKT,
    S_QDRAIN,
    S_DONE
  } ffc_state_e;

  // operand of the bucket divider
  typedef enum logic [1:0] {
    DSRC_LEVEL,
    DSRC_THR,
    DSRC_LIM
  } ffc_dsrc_e;

  typedef struct packed {
    logic      clear;
    logic      load;
    logic      key_read;
    logic      key_write;
    logic      set_sat;
    logic      set_absent;
    logic      phase;
    logic      div_start;
    ffc_dsrc_e div_src;
    logic      lvl_latch;
    logic      hb_read;
    logic      hb_write;
    logic      q_first;
    logic      q_last;
    logic      hist_walk;
    logic      bkt_walk;
    logic      out_load;
  } ffc_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_add;
    logic op_update;
    logic op_query;
    logic key_ok;
    logic thr_gt_lim;
    logic kc_sat;
    logic kc_absent;
    logic lvl_zero;
    logic div_done;
    logic f_last;
    logic b_empty;
    logic b_last;
  } ffc_sts_t;

endpackage

/* hdl/ffc_cdiv.sv */
// ffc_cdiv: divides a value by a fixed bucket size in three pipelined steps
// reciprocal multiply, back-multiply and subtract, one-step correction
// standalone, no package use
module ffc_cdiv #(
  parameter int unsigned DW  = 10,
  parameter int unsigned DIV = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] x_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned PW = 2 * DW + 1;
  localparam int unsigned EW = DW + 11;
  localparam logic [DW:0]   RecipM = (DW + 1)'((64'd1 << DW) / DIV);
  localparam logic [EW-1:0] DivK   = EW'(DIV);

  logic          v1_q, v2_q, v3_q;
  logic [DW-1:0] x1_q;
  logic [PW-1:0] prod_q;
  logic [DW-1:0] q2_q, r2_q;
  logic [DW-1:0] quo_q, rem_q;

  logic [DW:0]   q_est;
  logic [EW-1:0] back_prod;
  logic [EW-1:0] diff;
  logic [EW-1:0] rem_fix;

  // estimate is exact or one short
  always_comb begin
    q_est     = prod_q[PW-1:DW];
    back_prod = EW'(q_est[DW-1:0]) * DivK;
    diff      = EW'(x1_q) - back_prod;
    rem_fix   = EW'(r2_q) - DivK;
  end

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // data pipe
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x1_q   <= x_i;
      prod_q <= PW'(x_i) * PW'(RecipM);
    end
    if (v1_q) begin
      q2_q <= q_est[DW-1:0];
      r2_q <= diff[DW-1:0];
    end
    if (v2_q) begin
      if (EW'(r2_q) >= DivK) begin
        quo_q <= q2_q + DW'(1);
        rem_q <= rem_fix[DW-1:0];
      end else begin
        quo_q <= q2_q;
        rem_q <= r2_q;
      end
    end
  end

  assign done_o = v3_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/ffc_ctrl.sv */
// ffc_ctrl: controller state machine of the frequency-of-frequency counter
// sequences clearing, key update, histogram update and query walk
// depends on ffc_pkg
module ffc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ffc_pkg::ffc_sts_t sts_i,
  output ffc_pkg::ffc_cmd_t cmd_o
);

  import ffc_pkg::*;

  ffc_state_e state_q, state_d;
  logic       phase_q, phase_d;
  logic       out_valid_q, out_valid_d;
  ffc_cmd_t   cmd;
  logic       in_ready;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    cmd         = '0;
    cmd.phase   = phase_q;
    in_ready    = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op_query) begin
          if (sts_i.thr_gt_lim) begin
            state_d = S_DONE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DSRC_THR;
            state_d       = S_QDIVT;
          end
        end else if (sts_i.op_update && sts_i.key_ok) begin
          cmd.key_read = 1'b1;
          state_d      = S_KCHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_KCHK: begin
        if (sts_i.op_add && sts_i.kc_sat) begin
          cmd.set_sat = 1'b1;
          state_d     = S_DONE;
        end else if (!sts_i.op_add && sts_i.kc_absent) begin
          cmd.set_absent = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd.key_write = 1'b1;
          phase_d       = 1'b0;
          state_d       = S_LVL;
        end
      end
      // phase 0 lowers the old level, phase 1 raises the new one
      S_LVL: begin
        if (sts_i.lvl_zero) begin
          if (phase_q) begin
            state_d = S_DONE;
          end else begin
            phase_d = 1'b1;
          end
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DSRC_LEVEL;
          state_d       = S_LDIV;
        end
      end
      S_LDIV: begin
        if (sts_i.div_done) begin
          cmd.lvl_latch = 1'b1;
          state_d       = S_HRD;
        end
      end
      S_HRD: begin
        cmd.hb_read = 1'b1;
        state_d     = S_HWR;
      end
      S_HWR: begin
        cmd.hb_write = 1'b1;
        if (phase_q) begin
          state_d = S_DONE;
        end else begin
          phase_d = 1'b1;
          state_d = S_LVL;
        end
      end
      S_QDIVT: begin
        if (sts_i.div_done) begin
          cmd.q_first   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_src   = DSRC_LIM;
          state_d       = S_QDIVL;
        end
      end
      S_QDIVL: begin
        if (sts_i.div_done) begin
          cmd.q_last = 1'b1;
          state_d    = S_QHIST;
        end
      end
      // partial bucket, one histogram cell a cycle
      S_QHIST: begin
        cmd.hist_walk = 1'b1;
        if (sts_i.f_last) begin
          state_d = S_QBKT;
        end
      end
      // whole buckets, one sum a cycle
      S_QBKT: begin
        if (sts_i.b_empty) begin
          state_d = S_QDRAIN;
        end else begin
          cmd.bkt_walk = 1'b1;
          if (sts_i.b_last) begin
            state_d = S_QDRAIN;
          end
        end
      end
      S_QDRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign cmd_o       = cmd;
  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

/* hdl/ffc_dp.sv */
// ffc_dp: datapath of the frequency-of-frequency counter
// key count, histogram and bucket sum memories, query accumulator, limit
// register and result register; depends on ffc_pkg and ffc_cdiv
module ffc_dp #(
  parameter int unsigned KEYS        = 1024,
  parameter int unsigned MAX_COUNT   = 1023,
  parameter int unsigned BUCKET_SIZE = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffc_pkg::ffc_cmd_t           cmd_i,
  output ffc_pkg::ffc_sts_t           sts_o,
  input  logic [ffc_pkg::OP_W-1:0]    op_i,
  input  logic [ffc_pkg::KEY_W-1:0]   color_i,
  input  logic [ffc_pkg::THR_W-1:0]   threshold_i,
  input  logic                        cfg_we_i,
  input  logic [ffc_pkg::LIM_W-1:0]   cfg_data_i,
  output logic [ffc_pkg::CNT_W-1:0]   count_o,
  output logic [ffc_pkg::RES_W-1:0]   status_o
);

  import ffc_pkg::*;

  localparam int unsigned KAW = $clog2(KEYS);
  localparam int unsigned CW  = $clog2(MAX_COUNT + 1);
  localparam int unsigned HD  = MAX_COUNT + 1;
  localparam int unsigned HW  = $clog2(KEYS + 1);
  localparam int unsigned BD  = MAX_COUNT / BUCKET_SIZE + 1;
  localparam int unsigned BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int unsigned DW  = (CW > THR_W) ? CW : THR_W;
  localparam int unsigned EW  = DW + 11;
  localparam int unsigned CLR = (KEYS > HD) ? KEYS : HD;
  localparam int unsigned CLW = $clog2(CLR);
  localparam int unsigned AW  = (HW > CNT_W) ? HW : CNT_W;
  localparam int unsigned KXW = (KAW > KEY_W) ? KAW : KEY_W;

  // memories
  logic [CW-1:0] key_mem  [KEYS];
  logic [HW-1:0] hist_mem [HD];
  logic [HW-1:0] bkt_mem  [BD];

  // item and config registers
  logic [OP_W-1:0]  op_q;
  logic [KEY_W-1:0] color_q;
  logic [THR_W-1:0] thr_q;
  logic [LIM_W-1:0] limit_q;

  logic [CW-1:0]    kc_rd_q, c_q, cn_q;
  logic [HW-1:0]    hist_rd_q, bkt_rd_q;
  logic [BAW-1:0]   lb_q;
  logic [RES_W-1:0] status_q;
  logic [DW-1:0]    f_q, end_q;
  logic [DW:0]      b_q, blast_q;
  logic [AW-1:0]    acc_q;
  logic             hpend_q, bpend_q;
  logic [CLW-1:0]   clr_q;
  logic [CNT_W-1:0] count_q;
  logic [RES_W-1:0] res_q;

  logic [KXW-1:0] key_ext;
  logic [KAW-1:0] key_addr;
  logic [CW-1:0]  cn;
  logic [CW-1:0]  level;
  logic [DW-1:0]  lim, thr_w;
  logic [DW-1:0]  div_x, div_quo, div_rem;
  logic           div_done;
  logic [EW-1:0]  end_calc;
  logic [DW-1:0]  end_v;
  logic [CW-1:0]  hist_waddr, hist_raddr;
  logic [HW-1:0]  hist_wdata;
  logic [BAW-1:0] bkt_waddr, bkt_raddr;
  logic [HW-1:0]  bkt_wdata;
  logic           clr_key, clr_hist, clr_bkt;

  // decode and address logic
  always_comb begin
    key_ext  = KXW'(color_q);
    key_addr = key_ext[KAW-1:0];
    cn       = (op_q == OP_ADD) ? kc_rd_q + CW'(1) : kc_rd_q - CW'(1);
    level    = cmd_i.phase ? cn_q : c_q;
    thr_w    = DW'(thr_q);
    lim      = (DW'(limit_q) > DW'(MAX_COUNT)) ? DW'(MAX_COUNT) : DW'(limit_q);
    case (cmd_i.div_src)
      DSRC_LEVEL: div_x = DW'(level);
      DSRC_THR:   div_x = thr_w;
      DSRC_LIM:   div_x = lim;
      default:    div_x = '0;
    endcase
    // last cell of the threshold's bucket, clipped to the limit
    end_calc = EW'(thr_w) - EW'(div_rem) + EW'(BUCKET_SIZE - 1);
    end_v    = (end_calc > EW'(lim)) ? lim : end_calc[DW-1:0];
    clr_key  = cmd_i.clear && ((CLW + 1)'(clr_q) < (CLW + 1)'(KEYS));
    clr_hist = cmd_i.clear && ((CLW + 1)'(clr_q) < (CLW + 1)'(HD));
    clr_bkt  = cmd_i.clear && ((CLW + 1)'(clr_q) < (CLW + 1)'(BD));
    hist_waddr = cmd_i.clear ? clr_q[CW-1:0] : level;
    hist_raddr = cmd_i.hist_walk ? f_q[CW-1:0] : level;
    hist_wdata = cmd_i.clear ? '0 :
                 (cmd_i.phase ? hist_rd_q + HW'(1) : hist_rd_q - HW'(1));
    bkt_waddr  = cmd_i.clear ? clr_q[BAW-1:0] : lb_q;
    bkt_raddr  = cmd_i.bkt_walk ? b_q[BAW-1:0] : lb_q;
    bkt_wdata  = cmd_i.clear ? '0 :
                 (cmd_i.phase ? bkt_rd_q + HW'(1) : bkt_rd_q - HW'(1));
  end

  // status to the controller
  always_comb begin
    sts_o.clr_last   = (clr_q == CLW'(CLR - 1));
    sts_o.op_add     = (op_q == OP_ADD);
    sts_o.op_update  = (op_q == OP_ADD) || (op_q == OP_REMOVE);
    sts_o.op_query   = (op_q == OP_QUERY);
    sts_o.key_ok     = ((KXW + 1)'(color_q) < (KXW + 1)'(KEYS));
    sts_o.thr_gt_lim = (thr_w > lim);
    sts_o.kc_sat     = (kc_rd_q == CW'(MAX_COUNT));
    sts_o.kc_absent  = (kc_rd_q == '0);
    sts_o.lvl_zero   = (level == '0);
    sts_o.div_done   = div_done;
    sts_o.f_last     = (f_q == end_q);
    sts_o.b_empty    = (b_q > blast_q);
    sts_o.b_last     = (b_q == blast_q);
  end

  // shared bucket divider
  ffc_cdiv #(
    .DW  (DW),
    .DIV (BUCKET_SIZE)
  ) u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .x_i     (div_x),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // key count memory
  always_ff @(posedge clk_i) begin
    if (clr_key) begin
      key_mem[clr_q[KAW-1:0]] <= '0;
    end else if (cmd_i.key_write) begin
      key_mem[key_addr] <= cn;
    end
    if (cmd_i.key_read) begin
      kc_rd_q <= key_mem[key_addr];
    end
  end

  // histogram memory
  always_ff @(posedge clk_i) begin
    if (clr_hist || cmd_i.hb_write) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (cmd_i.hb_read || cmd_i.hist_walk) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  // bucket sum memory
  always_ff @(posedge clk_i) begin
    if (clr_bkt || cmd_i.hb_write) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    if (cmd_i.hb_read || cmd_i.bkt_walk) begin
      bkt_rd_q <= bkt_mem[bkt_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      limit_q <= LIMIT_RESET;
      hpend_q <= 1'b0;
      bpend_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + CLW'(1);
      end
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      hpend_q <= cmd_i.hist_walk;
      bpend_q <= cmd_i.bkt_walk;
    end
  end

  // item, walk and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= op_i;
      color_q  <= color_i;
      thr_q    <= threshold_i;
      status_q <= RES_OK;
      acc_q    <= '0;
    end else begin
      acc_q <= acc_q + (hpend_q ? AW'(hist_rd_q) : '0) + (bpend_q ? AW'(bkt_rd_q) : '0);
      if (cmd_i.set_sat) begin
        status_q <= RES_SAT;
      end else if (cmd_i.set_absent) begin
        status_q <= RES_ABSENT;
      end
    end
    if (cmd_i.key_write) begin
      c_q  <= kc_rd_q;
      cn_q <= cn;
    end
    if (cmd_i.lvl_latch) begin
      lb_q <= div_quo[BAW-1:0];
    end
    if (cmd_i.q_first) begin
      f_q   <= thr_w;
      end_q <= end_v;
      b_q   <= (DW + 1)'(div_quo) + (DW + 1)'(1);
    end else if (cmd_i.hist_walk) begin
      f_q <= f_q + DW'(1);
    end else if (cmd_i.bkt_walk) begin
      b_q <= b_q + (DW + 1)'(1);
    end
    if (cmd_i.q_last) begin
      blast_q <= (DW + 1)'(div_quo);
    end
    if (cmd_i.out_load) begin
      count_q <= acc_q[CNT_W-1:0];
      res_q   <= status_q;
    end
  end

  assign count_o  = count_q;
  assign status_o = res_q;

endmodule

/* hdl/frequency_of_frequency_counter.sv */
// frequency_of_frequency_counter: top level, per-key counts with a bucketed
// histogram of counts answering threshold queries
// depends on ffc_pkg, ffc_ctrl, ffc_dp (and ffc_cdiv below it)
//
//   channel  | signals                           | payload, low bit first
//   ---------+-----------------------------------+------------------------------
//   s_axis   | s_axis_tvalid/tready/tdata        | op[1:0] color[11:2] threshold[21:12]
//   m_axis   | m_axis_tvalid/tready/tdata        | count[10:0] status[12:11]
//   cfg      | cfg_valid_i/cfg_ready_o/cfg_data_i| frequency_limit[9:0], always ready
//
// after reset a clearing pass over max(KEYS, MAX_COUNT+1) addresses (1024 by default)
// zeroes the memories; s_axis_tready stays low meanwhile
// one item at a time: add/remove make at most two read-modify-write passes over the
// histogram and bucket sums, each behind the divider
// a query divides the threshold and the limit by the bucket size, then walks the cells
// of the threshold's bucket and the whole buckets up to the limit, one memory read a
// cycle; a threshold above the limit goes straight to the result
// a finished result waits in the output register; the next item is accepted meanwhile
module frequency_of_frequency_counter #(
  parameter int unsigned KEYS        = 1024,
  parameter int unsigned MAX_COUNT   = 1023,
  parameter int unsigned BUCKET_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ffc_pkg::IN_TDW-1:0]    s_axis_tdata,   // op, color, threshold
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ffc_pkg::OUT_TDW-1:0]   m_axis_tdata,   // count, status
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ffc_pkg::LIM_W-1:0]     cfg_data_i      // frequency_limit
);

  import ffc_pkg::*;

  localparam int unsigned KEY_LO = OP_W;
  localparam int unsigned THR_LO = OP_W + KEY_W;
  localparam int unsigned RES_LO = CNT_W;

  ffc_cmd_t         cmd;
  ffc_sts_t         sts;
  logic [CNT_W-1:0] count;
  logic [RES_W-1:0] status;

  // controller
  ffc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  ffc_dp #(
    .KEYS        (KEYS),
    .MAX_COUNT   (MAX_COUNT),
    .BUCKET_SIZE (BUCKET_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .op_i        (s_axis_tdata[OP_W-1:0]),
    .color_i     (s_axis_tdata[KEY_LO +: KEY_W]),
    .threshold_i (s_axis_tdata[THR_LO +: THR_W]),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .count_o     (count),
    .status_o    (status)
  );

  // result packing, zero filled to whole bytes
  always_comb begin
    m_axis_tdata                   = '0;
    m_axis_tdata[CNT_W-1:0]        = count;
    m_axis_tdata[RES_LO +: RES_W]  = status;
  end

  // limit register takes a transfer every cycle
  assign cfg_ready_o = 1'b1;

endmodule

/* test/tb.sv */
// tb: self-checking bench for frequency_of_frequency_counter
// streams add/remove/query items under random flow control, predicts every answer
// in a scoreboard class; depends on ffc_pkg and the counter rtl only
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffc_pkg::*;

  localparam int unsigned KEYS        = 1024;
  localparam int unsigned MAX_COUNT   = 1023;
  localparam int unsigned BUCKET_SIZE = 32;
  localparam int unsigned NUM_BUCKETS = MAX_COUNT / BUCKET_SIZE + 1;

  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] SAT_KEY   = 10'h0f0;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AFTER     = 400;
  localparam int unsigned TAIL_CYCLES    = 100;
  localparam int unsigned PHASE_ITEMS    = 130;
  localparam int unsigned NUM_HOT        = 12;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [RES_W-1:0] status;
  } answer_t;

  // predictor of the count store, the histogram and its bucket sums
  class freq_hist_scoreboard;
    bit [KEY_W-1:0]   key_level [KEYS];
    bit [CNT_W-1:0]   level_keys [MAX_COUNT+1];
    bit [CNT_W-1:0]   bucket_keys [NUM_BUCKETS];
    logic [LIM_W-1:0] limit;
    answer_t          expected_answers [$];
    int unsigned      failures, answered, n_query, n_sat, n_absent, n_limits;

    function new();
      limit = LIMIT_RESET;
    endfunction

    function void set_limit(logic [LIM_W-1:0] value);
      limit = value;
      n_limits++;
    endfunction

    // one key moves into or out of a histogram level; level zero is not kept
    function void shift_level(int unsigned level, bit up);
      if (level == 0 || level > MAX_COUNT) return;
      if (up) begin
        level_keys[level]++;
        bucket_keys[level / BUCKET_SIZE]++;
      end else begin
        level_keys[level]--;
        bucket_keys[level / BUCKET_SIZE]--;
      end
    endfunction

    // keys with a count from thr up to the limit: partial bucket, then whole buckets
    function logic [CNT_W-1:0] keys_at_or_above(int unsigned thr);
      int unsigned top, first_bkt, bkt_end, total;
      top = (limit > MAX_COUNT) ? MAX_COUNT : limit;
      total = 0;
      if (thr > top) return '0;
      first_bkt = thr / BUCKET_SIZE;
      bkt_end = (first_bkt + 1) * BUCKET_SIZE - 1;
      if (bkt_end > top) bkt_end = top;
      for (int unsigned f = thr; f <= bkt_end; f++) total += level_keys[f];
      for (int unsigned b = first_bkt + 1; b <= top / BUCKET_SIZE; b++)
        total += bucket_keys[b];
      return total[CNT_W-1:0];
    endfunction

    function void note_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] color,
                            logic [THR_W-1:0] thr);
      answer_t     ans;
      int unsigned lvl;
      ans.count  = '0;
      ans.status = RES_OK;
      lvl = key_level[color];
      case (op)
        OP_ADD: if (color < KEYS) begin
          if (lvl >= MAX_COUNT) begin
            ans.status = RES_SAT;
            n_sat++;
          end else begin
            shift_level(lvl, 1'b0);
            key_level[color] = KEY_W'(lvl + 1);
            shift_level(lvl + 1, 1'b1);
          end
        end
        OP_REMOVE: if (color < KEYS) begin
          if (lvl == 0) begin
            ans.status = RES_ABSENT;
            n_absent++;
          end else begin
            shift_level(lvl, 1'b0);
            key_level[color] = KEY_W'(lvl - 1);
            shift_level(lvl - 1, 1'b1);
          end
        end
        OP_QUERY: begin
          ans.count = keys_at_or_above(thr);
          n_query++;
        end
        default: ;
      endcase
      expected_answers = {expected_answers, ans};
    endfunction

    function void check_answer(logic [CNT_W-1:0] count, logic [RES_W-1:0] status);
      answer_t want;
      if (expected_answers.size() == 0) begin
        $error("result with nothing expected: count %0d status %0d", count, status);
        failures++;
        return;
      end
      want = expected_answers.pop_front();
      answered++;
      if (count !== want.count) begin
        $error("count mismatch: expected %0d, actual %0d", want.count, count);
        failures++;
      end
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        failures++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_TDW-1:0]    s_axis_tdata  = '0;   // op, color, threshold
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_TDW-1:0]   m_axis_tdata;         // count, status
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [LIM_W-1:0]     cfg_data_i    = '0;

  freq_hist_scoreboard board = new();
  bit                  no_idle = 1'b0;
  int unsigned         burst_left = 0;
  int unsigned         items_sent = 0;
  logic [KEY_W-1:0]    hot_keys [NUM_HOT];

  frequency_of_frequency_counter #(
    .KEYS        (KEYS),
    .MAX_COUNT   (MAX_COUNT),
    .BUCKET_SIZE (BUCKET_SIZE)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // transfer monitor feeding the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_item(s_axis_tdata[OP_W-1:0], s_axis_tdata[OP_W +: KEY_W],
                        s_axis_tdata[OP_W+KEY_W +: THR_W]);
      if (m_axis_tvalid && m_axis_tready)
        board.check_answer(m_axis_tdata[CNT_W-1:0], m_axis_tdata[CNT_W +: RES_W]);
      if (cfg_valid_i && cfg_ready_o) board.set_limit(cfg_data_i);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", quiet);
      $display("frequency_of_frequency_counter test failed");
      $finish;
    end
  end

  // result side: random stall windows, one long hold-off mid run
  initial begin : receiver
    int unsigned hold_left, win_left, stall_mode;
    bit          hold_done, ready_now;
    hold_left = 0;
    win_left  = 0;
    stall_mode = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && board.answered >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (win_left == 0) begin
        win_left   = $urandom_range(4, 32);
        stall_mode = $urandom_range(0, 3);
      end
      win_left--;
      case (stall_mode)
        0:       ready_now = 1'b1;
        1:       ready_now = ($urandom_range(0, 3) != 0);
        2:       ready_now = ($urandom_range(0, 1) != 0);
        default: ready_now = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ready_now;
      end
    end
  end

  // offer one item, in bursts with random gaps, and wait for its transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] color,
                           input logic [THR_W-1:0] thr);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0 || no_idle) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, thr, color, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // mostly updates on a few hot keys so counts climb across buckets
  task automatic send_random_item();
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] color;
    logic [THR_W-1:0] thr;
    int unsigned      pick, top;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_ADD;
    else if (pick < 68) op = OP_REMOVE;
    else if (pick < 95) op = OP_QUERY;
    else                op = OP_UNUSED;
    color = ($urandom_range(0, 3) != 0) ? hot_keys[$urandom_range(0, NUM_HOT-1)]
                                        : KEY_W'($urandom);
    top = (board.limit + 1 > MAX_COUNT) ? MAX_COUNT : board.limit + 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: thr = THR_W'($urandom_range(0, 70));
      5, 6, 7:       thr = THR_W'($urandom_range(0, top));
      default:       thr = THR_W'($urandom);
    endcase
    send_item(op, color, thr);
  endtask

  // stop offering and wait until every answer is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [LIM_W-1:0] limit_plan [7];
    limit_plan[0] = 10'd0;
    limit_plan[1] = 10'd1;
    limit_plan[2] = 10'd31;
    limit_plan[3] = 10'd32;
    limit_plan[4] = 10'd1023;
    limit_plan[5] = 10'd500;
    limit_plan[6] = LIM_W'($urandom_range(2, 1022));
    foreach (hot_keys[i]) hot_keys[i] = KEY_W'($urandom);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, absent removes, edge keys, bucket edges, unused op
    send_item(OP_QUERY, 10'd0, 10'd0);
    send_item(OP_REMOVE, 10'd0, 10'd0);
    send_item(OP_ADD, 10'd0, 10'h3ff);
    send_item(OP_ADD, 10'h3ff, 10'd0);
    send_item(OP_ADD, 10'h3ff, 10'd0);
    send_item(OP_ADD, 10'h2aa, 10'h155);
    send_item(OP_ADD, 10'h155, 10'h2aa);
    send_item(OP_QUERY, 10'h155, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1);
    send_item(OP_QUERY, 10'd0, 10'd2);
    send_item(OP_QUERY, 10'd0, 10'd3);
    send_item(OP_QUERY, 10'd0, 10'd31);
    send_item(OP_QUERY, 10'd0, 10'd32);
    send_item(OP_QUERY, 10'h3ff, 10'h3ff);
    send_item(OP_REMOVE, 10'h3ff, 10'd0);
    send_item(OP_REMOVE, 10'h3ff, 10'd0);
    send_item(OP_REMOVE, 10'h3ff, 10'h3ff);
    send_item(OP_UNUSED, 10'h3ff, 10'h3ff);
    send_item(OP_UNUSED, 10'd0, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1);
    drain();

    // one key driven to the top count and into saturation
    write_limit(LIMIT_RESET);
    for (int unsigned i = 0; i < MAX_COUNT; i++) begin
      send_item(OP_ADD, SAT_KEY, THR_W'($urandom));
      if (i % 64 == 63) send_item(OP_QUERY, 10'd0, THR_W'($urandom_range(0, i + 2)));
    end
    send_item(OP_ADD, SAT_KEY, 10'd0);
    send_item(OP_ADD, SAT_KEY, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1023);
    send_item(OP_QUERY, 10'd0, 10'd992);
    send_item(OP_QUERY, 10'd0, 10'd991);
    send_item(OP_REMOVE, SAT_KEY, 10'd0);
    send_item(OP_QUERY, 10'd0, 10'd1023);
    send_item(OP_QUERY, 10'd0, 10'd1022);
    drain();

    // random traffic under each limit setting, one phase without any idling
    foreach (limit_plan[p]) begin
      write_limit(limit_plan[p]);
      no_idle = (p == 3);
      repeat (PHASE_ITEMS) send_random_item();
      drain();
    end
    no_idle = 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d items: %0d queries, %0d saturated adds, %0d absent removes",
             items_sent, board.n_query, board.n_sat, board.n_absent);
    $display("%0d answers checked across %0d limit writes", board.answered,
             board.n_limits);
    if (board.failures == 0 && board.expected_answers.size() == 0)
      $display("frequency_of_frequency_counter test passed");
    else
      $display("frequency_of_frequency_counter test failed");
    $finish;
  end

endmodule
